FILE: rtl/core/iid_pkg.sv
// Shared types and constants for the IMU impact detector.
// Holds the sample and result transfer structs, register codes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iid_pkg;

  localparam int unsigned FIELD_W         = 16;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned NUM_AXES        = 6;

  localparam logic [CFG_W-1:0]   IMPACT_THR_RST   = 16'd10240;  // 2.5 g
  localparam logic [CFG_W-1:0]   ROTATION_THR_RST = 16'd19650;  // 300 deg/s
  localparam logic [CFG_W-1:0]   RESTING_LVL_RST  = 16'd4096;   // 1 g
  localparam logic [FIELD_W-1:0] MAG_MAX          = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMPACT_THR   = 2'd0,
    REG_ROTATION_THR = 2'd1,
    REG_RESTING_LVL  = 2'd2
  } iid_reg_e;

  typedef struct packed {
    logic signed [FIELD_W-1:0] accel_x;
    logic signed [FIELD_W-1:0] accel_y;
    logic signed [FIELD_W-1:0] accel_z;
    logic signed [FIELD_W-1:0] gyro_x;
    logic signed [FIELD_W-1:0] gyro_y;
    logic signed [FIELD_W-1:0] gyro_z;
  } iid_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] accel_magnitude;
    logic [FIELD_W-1:0] gyro_magnitude;
    logic               impact_hit;
    logic               rotation_hit;
    logic               crash;
  } iid_out_t;

endpackage

`default_nettype wire

FILE: rtl/core/iid_sq_lane.sv
// One axis lane: takes the low SAMPLE_BITS of the raw axis, takes its magnitude and squares it.
// Output is registered. Depends on iid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iid_sq_lane
  import iid_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic [FIELD_W-1:0]       raw_i,
  output      logic [2*SAMPLE_BITS-1:0] sq_o
);

  localparam int unsigned WIDE_W = (SAMPLE_BITS > FIELD_W) ? SAMPLE_BITS : FIELD_W;

  logic [WIDE_W-1:0]        wide;
  logic [SAMPLE_BITS-1:0]   val;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] sq_d, sq_q;

  // bits above the field read as zero when the sample is wider than the field
  assign wide = WIDE_W'(raw_i);
  assign val  = wide[SAMPLE_BITS-1:0];
  // most negative value wraps to 2^(N-1), which is its true magnitude unsigned
  assign mag  = val[SAMPLE_BITS-1] ? (~val + SAMPLE_BITS'(1)) : val;
  assign sq_d = {{SAMPLE_BITS{1'b0}}, mag} * {{SAMPLE_BITS{1'b0}}, mag};

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

FILE: rtl/core/iid_merge.sv
// Merge stage: sums the three squared accel lanes and the three squared gyro lanes.
// Registered sums with a valid flag. Depends on iid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iid_merge
  import iid_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     vld_i,
  input  wire logic [2*SAMPLE_BITS-1:0] sq_i [NUM_AXES],
  output      logic                     vld_o,
  output      logic [2*SAMPLE_BITS+1:0] acc_sum_o,
  output      logic [2*SAMPLE_BITS+1:0] gyr_sum_o
);

  localparam int unsigned SUM_W = 2 * SAMPLE_BITS + 2;

  logic             vld_q;
  logic [SUM_W-1:0] acc_d, acc_q, gyr_d, gyr_q;

  assign acc_d = SUM_W'(sq_i[0]) + SUM_W'(sq_i[1]) + SUM_W'(sq_i[2]);
  assign gyr_d = SUM_W'(sq_i[3]) + SUM_W'(sq_i[4]) + SUM_W'(sq_i[5]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    gyr_q <= gyr_d;
  end

  assign vld_o     = vld_q;
  assign acc_sum_o = acc_q;
  assign gyr_sum_o = gyr_q;

endmodule

`default_nettype wire

FILE: rtl/core/iid_sqrt_pipe.sv
// Pipelined floor square root, one result bit per stage (restoring, radix 2).
// IN_W must be even. Depends on iid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iid_sqrt_pipe
  import iid_pkg::*;
#(
  parameter int unsigned IN_W = 2 * SAMPLE_BITS_DEF + 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              vld_i,
  input  wire logic [IN_W-1:0]   rad_i,
  output      logic              vld_o,
  output      logic [IN_W/2-1:0] root_o
);

  localparam int unsigned RW    = IN_W / 2;
  localparam int unsigned REM_W = RW + 1;

  // partial radicand and remainder are not needed after the last stage
  logic [IN_W-1:0]  x_q    [RW-1];
  logic [REM_W-1:0] rem_q  [RW-1];
  logic [RW-1:0]    root_q [RW];
  logic             vld_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [IN_W-1:0]  x_in;
    logic [REM_W-1:0] rem_in;
    logic [RW-1:0]    root_in;
    logic             vld_in;
    logic [REM_W+1:0] rem_sh, trial, diff;
    logic             take;

    if (k == 0) begin : g_first
      assign x_in    = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign x_in    = x_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // bring down the next two radicand bits, try 4*root + 1
    assign rem_sh = {rem_in, x_in[IN_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign take   = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      root_q[k] <= {root_in[RW-2:0], take};
    end

    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        x_q[k]   <= {x_in[IN_W-3:0], 2'b00};
        rem_q[k] <= take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      end
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];

endmodule

`default_nettype wire

FILE: rtl/core/iid_flag_stage.sv
// Output stage: threshold compares, crash OR and 16-bit saturation of the magnitudes.
// Registers the result transfer and its strobe. Depends on iid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iid_flag_stage
  import iid_pkg::*;
#(
  parameter int unsigned RW = SAMPLE_BITS_DEF + 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             vld_i,
  input  wire logic [RW-1:0]    amag_i,
  input  wire logic [RW-1:0]    gmag_i,
  input  wire logic [CFG_W-1:0] impact_thr_i,
  input  wire logic [CFG_W-1:0] rotation_thr_i,
  input  wire logic [CFG_W-1:0] resting_lvl_i,
  output      logic             done_o,
  output      iid_out_t         result_o
);

  localparam int unsigned CW = (RW > FIELD_W) ? RW : FIELD_W;

  logic [CW-1:0] a_ext, g_ext, rest_ext, dev;
  logic          imp, rot;
  logic          done_q;
  iid_out_t      res_d, res_q;

  assign a_ext    = CW'(amag_i);
  assign g_ext    = CW'(gmag_i);
  assign rest_ext = CW'(resting_lvl_i);

  // compares run on the full-width magnitude, only the outputs saturate
  assign dev = (a_ext >= rest_ext) ? (a_ext - rest_ext) : (rest_ext - a_ext);
  assign imp = (dev >= CW'(impact_thr_i));
  assign rot = (g_ext >= CW'(rotation_thr_i));

  always_comb begin
    res_d.accel_magnitude = (a_ext > CW'(MAG_MAX)) ? MAG_MAX : a_ext[FIELD_W-1:0];
    res_d.gyro_magnitude  = (g_ext > CW'(MAG_MAX)) ? MAG_MAX : g_ext[FIELD_W-1:0];
    res_d.impact_hit      = imp;
    res_d.rotation_hit    = rot;
    res_d.crash           = imp | rot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

FILE: rtl/core/imu_impact_detector.sv
// IMU impact detector: top level, fully pipelined, one sample per clock.
// Depends on iid_pkg, iid_sq_lane, iid_merge, iid_sqrt_pipe, iid_flag_stage.
`timescale 1ns / 1ps
`default_nettype none

// Takes one inertial sample per transfer (start_i high while busy_o is low;
// busy_o never rises, so a sample may be offered every cycle). For each
// sample exactly one result appears on result_o with done_o high for a single
// cycle. It is registered in order by the axis squarers, the sum merge, the
// square root and the output compare. The receiver cannot stall: it must
// take every result in the cycle it is shown. The square root retires one
// root bit per pipeline stage (SAMPLE_BITS + 1 stages). Magnitudes are floor
// square roots in raw sensor units and saturate at 65535; the flags compare
// against the unsaturated value. Thresholds and the resting level are
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i and must only change
// while no sample is in flight; unused indexes are ignored.
module imu_impact_detector
  import iid_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // sample transfer
  input  wire logic                 start_i,
  output      logic                 busy_o,
  input  wire iid_in_t              sample_i,
  // result transfer
  output      logic                 done_o,
  output      iid_out_t             result_o,
  // register writes
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS;
  localparam int unsigned SUM_W = SQ_W + 2;
  localparam int unsigned RW    = SUM_W / 2;
  localparam int unsigned LAT   = RW + 3;  // accept edge to result edge

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] impact_thr_q, rotation_thr_q, resting_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      impact_thr_q   <= IMPACT_THR_RST;
      rotation_thr_q <= ROTATION_THR_RST;
      resting_lvl_q  <= RESTING_LVL_RST;
    end else if (cfg_we_i) begin
      unique case (iid_reg_e'(cfg_idx_i))
        REG_IMPACT_THR:   impact_thr_q   <= cfg_wdata_i;
        REG_ROTATION_THR: rotation_thr_q <= cfg_wdata_i;
        REG_RESTING_LVL:  resting_lvl_q  <= cfg_wdata_i;
        default: ;  // no register behind this index
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input transfer: the pipeline never holds, so every start is taken
  // ---------------------------------------------------------------------------
  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // ---------------------------------------------------------------------------
  // Axis lanes: six squarers side by side, accel x/y/z then gyro x/y/z
  // ---------------------------------------------------------------------------
  logic [FIELD_W-1:0] axis_raw [NUM_AXES];
  logic [SQ_W-1:0]    axis_sq  [NUM_AXES];
  logic               sq_vld_q;

  assign axis_raw[0] = sample_i.accel_x;
  assign axis_raw[1] = sample_i.accel_y;
  assign axis_raw[2] = sample_i.accel_z;
  assign axis_raw[3] = sample_i.gyro_x;
  assign axis_raw[4] = sample_i.gyro_y;
  assign axis_raw[5] = sample_i.gyro_z;

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    iid_sq_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .raw_i (axis_raw[i]),
      .sq_o  (axis_sq[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else begin
      sq_vld_q <= accept;
    end
  end

  // ---------------------------------------------------------------------------
  // Merge: squared lengths of both vectors
  // ---------------------------------------------------------------------------
  logic             sum_vld;
  logic [SUM_W-1:0] acc_sum, gyr_sum;

  iid_merge #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (sq_vld_q),
    .sq_i      (axis_sq),
    .vld_o     (sum_vld),
    .acc_sum_o (acc_sum),
    .gyr_sum_o (gyr_sum)
  );

  // ---------------------------------------------------------------------------
  // Square roots: two identical pipelines running in lockstep
  // ---------------------------------------------------------------------------
  logic          a_vld, g_vld;
  logic [RW-1:0] amag, gmag;

  iid_sqrt_pipe #(
    .IN_W(SUM_W)
  ) u_sqrt_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (sum_vld),
    .rad_i  (acc_sum),
    .vld_o  (a_vld),
    .root_o (amag)
  );

  iid_sqrt_pipe #(
    .IN_W(SUM_W)
  ) u_sqrt_gyr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (sum_vld),
    .rad_i  (gyr_sum),
    .vld_o  (g_vld),
    .root_o (gmag)
  );

  // ---------------------------------------------------------------------------
  // Threshold compare and result register
  // ---------------------------------------------------------------------------
  iid_flag_stage #(
    .RW(RW)
  ) u_flags (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vld_i          (a_vld & g_vld),
    .amag_i         (amag),
    .gmag_i         (gmag),
    .impact_thr_i   (impact_thr_q),
    .rotation_thr_i (rotation_thr_q),
    .resting_lvl_i  (resting_lvl_q),
    .done_o         (done_o),
    .result_o       (result_o)
  );

`ifndef SYNTHESIS
  // the two root pipelines must never drift apart
  a_roots_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld == g_vld)
    else $error("accel and gyro root pipelines out of step");

  // a result only ever follows an accepted sample by the fixed latency
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result strobe without a matching sample");

  // a gyro magnitude below threshold cannot have raised the rotation flag
  a_rot_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.gyro_magnitude < rotation_thr_q)) |-> !result_o.rotation_hit)
    else $error("rotation flag disagrees with gyro magnitude");
`endif

endmodule

`default_nettype wire
